/* rtl/ddwc_pkg.sv */
`default_nettype none

package ddwc_pkg;

    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned VEL_W    = 16;
    localparam int unsigned DIST_W   = 16;
    localparam int unsigned PROD_W   = VEL_W + GAIN_W + 1;
    localparam int unsigned SUM_W    = PROD_W + 1;
    localparam int unsigned MAG_W    = 7;
    localparam int unsigned IDX_W    = 4;

    // frame bytes
    localparam logic [7:0] HDR0      = 8'hcd;
    localparam logic [7:0] HDR1      = 8'heb;
    localparam logic [7:0] HDR2      = 8'hd7;
    localparam logic [7:0] CMD_HDR3  = 8'h09;
    localparam logic [7:0] CMD_HDR4  = 8'h74;
    localparam logic [7:0] CAL_HDR3  = 8'h01;
    localparam logic [7:0] CAL_HDR4  = 8'h43;
    localparam logic [7:0] DIR_F     = 8'h46;
    localparam logic [7:0] DIR_B     = 8'h42;
    localparam logic [7:0] DIR_S     = 8'h53;
    localparam logic [7:0] PAD_BYTE  = 8'h00;

    // byte positions
    localparam logic [IDX_W-1:0] POS_HDR0  = 4'd0;
    localparam logic [IDX_W-1:0] POS_HDR1  = 4'd1;
    localparam logic [IDX_W-1:0] POS_HDR2  = 4'd2;
    localparam logic [IDX_W-1:0] POS_HDR3  = 4'd3;
    localparam logic [IDX_W-1:0] POS_HDR4  = 4'd4;
    localparam logic [IDX_W-1:0] POS_DIR_R = 4'd5;
    localparam logic [IDX_W-1:0] POS_DIR_L = 4'd6;
    localparam logic [IDX_W-1:0] POS_S0    = 4'd7;
    localparam logic [IDX_W-1:0] POS_S1    = 4'd8;
    localparam logic [IDX_W-1:0] POS_MAG_R = 4'd9;
    localparam logic [IDX_W-1:0] POS_MAG_L = 4'd10;
    localparam logic [IDX_W-1:0] LAST_CAL  = 4'd4;
    localparam logic [IDX_W-1:0] LAST_CMD  = 4'd12;

    // obstacle thresholds
    localparam logic [DIST_W-1:0] SIDE_FAR  = 16'd30;
    localparam logic [DIST_W-1:0] SIDE_NEAR = 16'd15;
    localparam logic [DIST_W-1:0] REAR_NEAR = 16'd20;

    localparam logic [1:0] STATUS_INIT     = 2'd0;
    localparam logic [1:0] STATUS_OBSTACLE = 2'd2;

    localparam logic       REQ_VELOCITY    = 1'b0;
    localparam logic       REQ_CALIBRATE   = 1'b1;

    localparam logic       CFG_LINEAR_GAIN  = 1'b0;
    localparam logic       CFG_ANGULAR_GAIN = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CAL  = 2'd1,
        KIND_CMD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic lf_far;
        logic lf_near;
        logic rf_far;
        logic rf_near;
        logic rear_near;
    } near_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       dir_r;
        logic [7:0]       dir_l;
        logic [MAG_W-1:0] mag_r;
        logic [MAG_W-1:0] mag_l;
    } frame_t;

    function automatic logic [7:0] frame_byte_f(frame_t f, logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = PAD_BYTE;
        case (idx)
            POS_HDR0:  b = HDR0;
            POS_HDR1:  b = HDR1;
            POS_HDR2:  b = HDR2;
            POS_HDR3:  b = (f.kind == KIND_CAL) ? CAL_HDR3 : CMD_HDR3;
            POS_HDR4:  b = (f.kind == KIND_CAL) ? CAL_HDR4 : CMD_HDR4;
            POS_DIR_R: b = f.dir_r;
            POS_DIR_L: b = f.dir_l;
            POS_S0:    b = DIR_S;
            POS_S1:    b = DIR_S;
            POS_MAG_R: b = {1'b0, f.mag_r};
            POS_MAG_L: b = {1'b0, f.mag_l};
            default:   b = PAD_BYTE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/ddwc_kin.sv */
`default_nettype none

module ddwc_kin (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [ddwc_pkg::GAIN_W-1:0]           linear_gain,
    input  wire logic [ddwc_pkg::GAIN_W-1:0]           angular_gain,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  req_type,
    input  wire logic                                  calibrate_flag,
    input  wire logic signed [ddwc_pkg::VEL_W-1:0]     linear_velocity,
    input  wire logic signed [ddwc_pkg::VEL_W-1:0]     angular_velocity,
    input  wire logic [1:0]                            base_status,
    input  wire logic [ddwc_pkg::DIST_W-1:0]           left_front_distance,
    input  wire logic [ddwc_pkg::DIST_W-1:0]           right_front_distance,
    input  wire logic [ddwc_pkg::DIST_W-1:0]           rear_distance,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output ddwc_pkg::frame_t                           out_frame
);

    localparam int unsigned PW = ddwc_pkg::PROD_W;
    localparam int unsigned SW = ddwc_pkg::SUM_W;
    localparam int unsigned MW = ddwc_pkg::MAG_W;
    localparam logic signed [SW-1:0] LIMIT_Q16 = SW'(100 * 65536);
    localparam logic [MW-1:0]        MAG_MAX   = MW'(100);

    // stage valids
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // stage 1: products, obstacle flags
    ddwc_pkg::kind_t         kind1_reg, kind1_next;
    ddwc_pkg::near_t         near1_reg, near1_next;
    logic signed [PW-1:0]    lin1_reg, lin1_next;
    logic signed [PW-1:0]    ang1_reg, ang1_next;

    // stage 2: wheel sums
    ddwc_pkg::kind_t         kind2_reg;
    ddwc_pkg::near_t         near2_reg;
    logic signed [SW-1:0]    right2_reg, right2_next;
    logic signed [SW-1:0]    left2_reg, left2_next;

    // stage 3: frame descriptor
    ddwc_pkg::frame_t        frame3_reg, frame3_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    function automatic logic near_f(logic [ddwc_pkg::DIST_W-1:0] d,
                                    logic [ddwc_pkg::DIST_W-1:0] lim);
        return (d != '0) && (d < lim);
    endfunction

    always_comb
    begin
        logic chk;
        chk = (base_status == ddwc_pkg::STATUS_OBSTACLE);
        if (req_type == ddwc_pkg::REQ_CALIBRATE)
        begin
            kind1_next = calibrate_flag ? ddwc_pkg::KIND_CAL : ddwc_pkg::KIND_NONE;
        end
        else
        begin
            kind1_next = (base_status == ddwc_pkg::STATUS_INIT) ? ddwc_pkg::KIND_NONE
                                                                : ddwc_pkg::KIND_CMD;
        end
        near1_next.lf_far    = chk && near_f(left_front_distance, ddwc_pkg::SIDE_FAR);
        near1_next.lf_near   = chk && near_f(left_front_distance, ddwc_pkg::SIDE_NEAR);
        near1_next.rf_far    = chk && near_f(right_front_distance, ddwc_pkg::SIDE_FAR);
        near1_next.rf_near   = chk && near_f(right_front_distance, ddwc_pkg::SIDE_NEAR);
        near1_next.rear_near = chk && near_f(rear_distance, ddwc_pkg::REAR_NEAR);
        lin1_next = PW'(linear_velocity) * PW'($signed({1'b0, linear_gain}));
        ang1_next = PW'(angular_velocity) * PW'($signed({1'b0, angular_gain}));
    end

    assign right2_next = {lin1_reg[PW-1], lin1_reg} + {ang1_reg[PW-1], ang1_reg};
    assign left2_next  = {lin1_reg[PW-1], lin1_reg} - {ang1_reg[PW-1], ang1_reg};

    // clamp to +-100 percent, truncate toward zero
    function automatic void wheel_f(input  logic signed [SW-1:0] q,
                                    output logic [7:0]           dir,
                                    output logic [MW-1:0]        mag);
        logic             neg;
        logic             sat;
        logic [SW-1:0]    mag_q;
        neg   = q[SW-1];
        sat   = neg ? (q < -LIMIT_Q16) : (q > LIMIT_Q16);
        mag_q = neg ? SW'(-q) : SW'(q);
        mag   = sat ? MAG_MAX : mag_q[16 +: MW];
        if (mag == '0)
        begin
            dir = ddwc_pkg::DIR_S;
        end
        else
        begin
            dir = neg ? ddwc_pkg::DIR_B : ddwc_pkg::DIR_F;
        end
    endfunction

    always_comb
    begin
        logic [7:0]    dr, dl;
        logic [MW-1:0] mr, ml;
        wheel_f(right2_reg, dr, mr);
        wheel_f(left2_reg, dl, ml);
        // obstacle rules apply in order, each sees the previous result
        if (near2_reg.lf_far && dl == ddwc_pkg::DIR_F)
        begin
            dl = ddwc_pkg::DIR_S;
        end
        if (near2_reg.rf_far && dr == ddwc_pkg::DIR_F)
        begin
            dr = ddwc_pkg::DIR_S;
        end
        if (near2_reg.rear_near && (dr == ddwc_pkg::DIR_B || dl == ddwc_pkg::DIR_B))
        begin
            dr = ddwc_pkg::DIR_S;
            dl = ddwc_pkg::DIR_S;
        end
        if (near2_reg.lf_near && (dr == ddwc_pkg::DIR_F || dl == ddwc_pkg::DIR_F))
        begin
            dr = ddwc_pkg::DIR_S;
            dl = ddwc_pkg::DIR_S;
        end
        if (near2_reg.rf_near && (dr == ddwc_pkg::DIR_F || dl == ddwc_pkg::DIR_F))
        begin
            dr = ddwc_pkg::DIR_S;
            dl = ddwc_pkg::DIR_S;
        end
        frame3_next.kind  = kind2_reg;
        frame3_next.dir_r = dr;
        frame3_next.dir_l = dl;
        frame3_next.mag_r = mr;
        frame3_next.mag_l = ml;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            kind1_reg <= kind1_next;
            near1_reg <= near1_next;
            lin1_reg  <= lin1_next;
            ang1_reg  <= ang1_next;
        end
        if (rdy2)
        begin
            kind2_reg  <= kind1_reg;
            near2_reg  <= near1_reg;
            right2_reg <= right2_next;
            left2_reg  <= left2_next;
        end
        if (rdy3)
        begin
            frame3_reg <= frame3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_frame = frame3_reg;

endmodule

`default_nettype wire

/* rtl/ddwc_ser.sv */
`default_nettype none

module ddwc_ser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ddwc_pkg::frame_t  in_frame,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    localparam int unsigned IW = ddwc_pkg::IDX_W;

    logic              busy_reg, busy_next;
    logic [IW-1:0]     idx_reg, idx_next;
    ddwc_pkg::frame_t  frame_reg;
    logic              oval_reg, oval_next;
    logic [7:0]        obyte_reg;
    logic              olast_reg;

    logic              out_load;
    logic              emit;
    logic              last;
    logic              load;

    assign out_load = !oval_reg || out_ready;
    assign emit     = busy_reg && out_load;
    assign last     = (frame_reg.kind == ddwc_pkg::KIND_CAL && idx_reg == ddwc_pkg::LAST_CAL)
                   || (frame_reg.kind == ddwc_pkg::KIND_CMD && idx_reg == ddwc_pkg::LAST_CMD);
    // next frame is taken in the same cycle the last byte goes out
    assign in_ready = !busy_reg || (emit && last);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = (in_frame.kind != ddwc_pkg::KIND_NONE);
            idx_next  = '0;
        end
        else if (emit)
        begin
            busy_next = !last;
            idx_next  = idx_reg + IW'(1);
        end
        oval_next = emit ? 1'b1 : (out_ready ? 1'b0 : oval_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= in_frame;
        end
        if (emit)
        begin
            obyte_reg <= ddwc_pkg::frame_byte_f(frame_reg, idx_reg);
            olast_reg <= last;
        end
    end

    assign out_valid = oval_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

/* rtl/diff_drive_wheel_command_framer.sv */
// differential drive wheel command framer
//
// s_axis: one request per transfer. a velocity request (tuser[0] = 0) with a
// nonzero status turns into a 13-byte wheel command frame; a calibration request
// (tuser[0] = 1) with the flag set turns into the 5-byte imu calibration frame;
// everything else is consumed and gives nothing.
// m_axis: one frame byte per transfer, tlast on the final byte of each frame.
// cfg: cfg_we with cfg_index 0 writes linear_gain, index 1 writes angular_gain;
// write only while the block is idle.
// a request passes through the multiply, wheel sum, clamp and obstacle rule
// stages, then the byte serializer, before its first byte is valid.
// requests enter every cycle until the pipeline fills; the sustained rate is
// set by the serializer at one byte per cycle while m_tready is high.
// reset clears all valid bits and both gains. when m_tready is low the byte
// held in the output register stays and the three stages fill, then s_tready
// drops; nothing is lost or repeated.
`default_nettype none

module diff_drive_wheel_command_framer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [ddwc_pkg::GAIN_W-1:0]  cfg_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // linear_velocity, angular_velocity, base_status, left_front_distance,
    // right_front_distance, rear_distance, zero pad
    input  wire logic [87:0]                  s_tdata,
    // req_type, calibrate_flag
    input  wire logic [1:0]                   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // frame_byte
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast
);

    logic [ddwc_pkg::GAIN_W-1:0] linear_gain_reg;
    logic [ddwc_pkg::GAIN_W-1:0] angular_gain_reg;

    logic              fr_valid;
    logic              fr_ready;
    ddwc_pkg::frame_t  fr_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_gain_reg  <= '0;
            angular_gain_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddwc_pkg::CFG_LINEAR_GAIN:  linear_gain_reg  <= cfg_data;
                ddwc_pkg::CFG_ANGULAR_GAIN: angular_gain_reg <= cfg_data;
                default:                    linear_gain_reg  <= linear_gain_reg;
            endcase
        end
    end

    ddwc_kin u_kin (
        .clk                  (clk),
        .rst_n                (rst_n),
        .linear_gain          (linear_gain_reg),
        .angular_gain         (angular_gain_reg),
        .in_valid             (s_tvalid),
        .in_ready             (s_tready),
        .req_type             (s_tuser[0]),
        .calibrate_flag       (s_tuser[1]),
        .linear_velocity      ($signed(s_tdata[15:0])),
        .angular_velocity     ($signed(s_tdata[31:16])),
        .base_status          (s_tdata[33:32]),
        .left_front_distance  (s_tdata[49:34]),
        .right_front_distance (s_tdata[65:50]),
        .rear_distance        (s_tdata[81:66]),
        .out_valid            (fr_valid),
        .out_ready            (fr_ready),
        .out_frame            (fr_frame)
    );

    ddwc_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_frame  (fr_frame),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/ddwc_checker.sv */
`default_nettype none

module ddwc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tlast
);

    logic xfer;
    logic frame_start_reg;

    assign xfer = m_tvalid && m_tready;

    // set between frames: the next byte out opens a new frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= 1'b1;
        end
        else if (xfer)
        begin
            frame_start_reg <= m_tlast;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transfer dropped or changed while stalled");

    // checked after reset is seen; the flops clear asynchronously as soon as reset is asserted
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && frame_start_reg |-> m_tdata == ddwc_pkg::HDR0 && !m_tlast)
        else $error("frame does not open with header byte");

    a_frame_tail: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && m_tlast |-> m_tdata == ddwc_pkg::PAD_BYTE || m_tdata == ddwc_pkg::CAL_HDR4)
        else $error("unexpected final byte of frame");

endmodule

bind diff_drive_wheel_command_framer ddwc_checker u_ddwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
